[design/rcm_pkg.sv]
package rcm_pkg;

  localparam int ADC_BITS      = 10;
  localparam int MAX_WINDOW    = 4096;
  localparam int CALIB_SAMPLES = 10;

  localparam int SAMPLE_W  = ADC_BITS;
  localparam int SQ_W      = 2 * ADC_BITS;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int CSUM_W    = 14;
  localparam int CCNT_W    = 4;
  localparam int SENS_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int MA_W      = 17;

  localparam int FRAC_BITS = 4;
  localparam int RAD_W     = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SREM_W    = ROOT_W + 1;
  localparam int SCNT_W    = $clog2(ROOT_W);

  localparam int SCALE_NUM   = 5000 * 1000;
  localparam int SCALE_NUM_W = $clog2(SCALE_NUM + 1);
  localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
  localparam int SCALE_DEN   = (1 << FRAC_BITS) * ADC_MAX;
  localparam int SCALE_DEN_W = $clog2(SCALE_DEN + 1);

  localparam int DIV_W   = ROOT_W + SCALE_NUM_W;
  localparam int DEN_W   = SCALE_DEN_W + SENS_W;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam int CURRENT_MAX = 100000;

  localparam int CALIB_SHIFT  = 19;
  localparam int CALIB_RECIP  = ((1 << CALIB_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int CALIB_PROD_W = CSUM_W + CALIB_SHIFT - 3;

  localparam logic [SENS_W-1:0]   SENS_RESET    = 8'd185;
  localparam logic [SAMPLE_W-1:0] NEUTRAL_RESET = 10'd512;

  localparam logic [CFG_IDX_W-1:0] REG_SENS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 2'd1;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CALIB   = 1'b1;

  localparam logic KIND_RMS   = 1'b0;
  localparam logic KIND_CALIB = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
    logic                sat;
    logic [SAMPLE_W-1:0] neutral;
    logic [SENS_W-1:0]   sens;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV1,
    B_SQRT,
    B_MUL,
    B_DIV2,
    B_OUT
  } back_state_t;

endpackage

[design/rcm_front.sv]
module rcm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_opcode,
  input  logic [rcm_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           in_window_end,
  input  logic                           cfg_we,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcm_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                           job_full,
  output logic                           job_push,
  output rcm_pkg::job_t                  job
);

  logic [rcm_pkg::SUM_W-1:0]    square_sum_r, square_sum_nxt;
  logic [rcm_pkg::CNT_W-1:0]    sample_count_r, sample_count_nxt;
  logic                         sat_r, sat_nxt;
  logic [rcm_pkg::CSUM_W-1:0]   calib_sum_r, calib_sum_nxt;
  logic [rcm_pkg::CCNT_W-1:0]   calib_count_r, calib_count_nxt;
  logic [rcm_pkg::SAMPLE_W-1:0] neutral_r, neutral_nxt;
  logic [rcm_pkg::SENS_W-1:0]   sens_r, sens_nxt;

  logic                            accept;
  logic [rcm_pkg::SAMPLE_W-1:0]    diff;
  logic [rcm_pkg::SQ_W-1:0]        square;
  logic [rcm_pkg::SUM_W:0]         sum_ext;
  logic [rcm_pkg::SUM_W-1:0]       sum_new;
  logic                            sat_new;
  logic [rcm_pkg::CNT_W-1:0]       count_new;
  logic [rcm_pkg::CSUM_W-1:0]      csum_new;
  logic [rcm_pkg::CCNT_W-1:0]      ccnt_new;
  logic [rcm_pkg::CALIB_PROD_W-1:0] calib_prod;
  logic [rcm_pkg::SAMPLE_W-1:0]    calib_avg;

  assign accept = in_push && !job_full;

  always_comb begin
    diff = (in_sample >= neutral_r) ? in_sample - neutral_r : neutral_r - in_sample;
    square = rcm_pkg::SQ_W'(diff) * rcm_pkg::SQ_W'(diff);
    sum_ext = {1'b0, square_sum_r} + (rcm_pkg::SUM_W + 1)'(square);
    sum_new = sum_ext[rcm_pkg::SUM_W] ? '1 : sum_ext[rcm_pkg::SUM_W-1:0];
    sat_new = sat_r || sum_ext[rcm_pkg::SUM_W];
    count_new = (sample_count_r < rcm_pkg::CNT_W'(rcm_pkg::MAX_WINDOW))
                ? sample_count_r + 1'b1 : sample_count_r;

    csum_new = calib_sum_r + rcm_pkg::CSUM_W'(in_sample);
    ccnt_new = calib_count_r + 1'b1;
    calib_prod = rcm_pkg::CALIB_PROD_W'(csum_new) *
                 rcm_pkg::CALIB_PROD_W'(rcm_pkg::CALIB_RECIP);
    calib_avg = calib_prod[rcm_pkg::CALIB_SHIFT +: rcm_pkg::SAMPLE_W];
  end

  always_comb begin
    square_sum_nxt   = square_sum_r;
    sample_count_nxt = sample_count_r;
    sat_nxt          = sat_r;
    calib_sum_nxt    = calib_sum_r;
    calib_count_nxt  = calib_count_r;
    neutral_nxt      = neutral_r;
    sens_nxt         = sens_r;
    job_push         = 1'b0;
    job              = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        rcm_pkg::REG_SENS:    sens_nxt = cfg_wdata[rcm_pkg::SENS_W-1:0];
        rcm_pkg::REG_NEUTRAL: neutral_nxt = cfg_wdata[rcm_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      if (in_opcode == rcm_pkg::OP_CALIB) begin
        if (ccnt_new >= rcm_pkg::CCNT_W'(rcm_pkg::CALIB_SAMPLES)) begin
          neutral_nxt     = calib_avg;
          calib_sum_nxt   = '0;
          calib_count_nxt = '0;
          job_push        = 1'b1;
          job.kind        = rcm_pkg::KIND_CALIB;
          job.neutral     = calib_avg;
        end else begin
          calib_sum_nxt   = csum_new;
          calib_count_nxt = ccnt_new;
        end
      end else if (in_window_end) begin
        square_sum_nxt   = '0;
        sample_count_nxt = '0;
        sat_nxt          = 1'b0;
        job_push         = 1'b1;
        job.kind         = rcm_pkg::KIND_RMS;
        job.sum          = sum_new;
        job.count        = count_new;
        job.sat          = sat_new;
        job.neutral      = neutral_r;
        job.sens         = sens_r;
      end else begin
        square_sum_nxt   = sum_new;
        sample_count_nxt = count_new;
        sat_nxt          = sat_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_sum_r   <= '0;
      sample_count_r <= '0;
      sat_r          <= 1'b0;
      calib_sum_r    <= '0;
      calib_count_r  <= '0;
      neutral_r      <= rcm_pkg::NEUTRAL_RESET;
      sens_r         <= rcm_pkg::SENS_RESET;
    end else begin
      square_sum_r   <= square_sum_nxt;
      sample_count_r <= sample_count_nxt;
      sat_r          <= sat_nxt;
      calib_sum_r    <= calib_sum_nxt;
      calib_count_r  <= calib_count_nxt;
      neutral_r      <= neutral_nxt;
      sens_r         <= sens_nxt;
    end
  end

endmodule

[design/rcm_job_fifo.sv]
module rcm_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rcm_pkg::job_t din,
  input  logic          pop,
  output rcm_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  rcm_pkg::job_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[design/rcm_div.sv]
module rcm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rcm_pkg::DIV_W-1:0]   dividend,
  input  logic [rcm_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [rcm_pkg::DIV_W-1:0]   quotient
);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [rcm_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rcm_pkg::DIV_W-1:0]   q_r, q_nxt;
  logic [rcm_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [rcm_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [rcm_pkg::DEN_W:0]     trial;
  logic [rcm_pkg::DEN_W:0]     diff;
  logic                        ge;

  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    trial    = {rem_r, q_r[rcm_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
    end else if (run_r) begin
      q_nxt   = {q_r[rcm_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? diff[rcm_pkg::DEN_W-1:0] : trial[rcm_pkg::DEN_W-1:0];
      if (cnt_r == rcm_pkg::DCNT_W'(rcm_pkg::DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

[design/rcm_back.sv]
module rcm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_empty,
  input  rcm_pkg::job_t                 job_head,
  output logic                          job_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic                          out_kind,
  output logic [rcm_pkg::MA_W-1:0]      out_current_ma,
  output logic [rcm_pkg::SAMPLE_W-1:0]  out_neutral_code,
  output logic [rcm_pkg::CNT_W-1:0]     out_window_samples,
  output logic                          out_overflow
);

  rcm_pkg::back_state_t state_r, state_nxt;

  rcm_pkg::job_t                job_r;
  logic [rcm_pkg::RAD_W-1:0]    rad_r;
  logic [rcm_pkg::ROOT_W-1:0]   root_r;
  logic [rcm_pkg::SREM_W-1:0]   srem_r;
  logic [rcm_pkg::SCNT_W-1:0]   scnt_r;
  logic [rcm_pkg::MA_W-1:0]     ma_r;

  logic                         out_valid_r;
  logic                         out_kind_r;
  logic [rcm_pkg::MA_W-1:0]     out_ma_r;
  logic [rcm_pkg::SAMPLE_W-1:0] out_neut_r;
  logic [rcm_pkg::CNT_W-1:0]    out_cnt_r;
  logic                         out_ovf_r;

  logic                         div_start;
  logic [rcm_pkg::DIV_W-1:0]    div_dividend;
  logic [rcm_pkg::DEN_W-1:0]    div_divisor;
  logic                         div_done;
  logic [rcm_pkg::DIV_W-1:0]    div_q;

  logic                         out_free;
  logic                         out_load;
  logic                         sqrt_last;
  logic [rcm_pkg::CNT_W-1:0]    cnt_eff;
  logic [rcm_pkg::SENS_W-1:0]   sens_eff;
  logic [rcm_pkg::SREM_W+1:0]   s_trem;
  logic [rcm_pkg::SREM_W+1:0]   s_trial;
  logic                         s_ge;
  logic [rcm_pkg::MA_W-1:0]     ma_clamped;

  rcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free  = !out_valid_r || out_pop;
  assign sqrt_last = (scnt_r == rcm_pkg::SCNT_W'(rcm_pkg::ROOT_W - 1));

  always_comb begin
    cnt_eff  = (job_head.count == '0) ? rcm_pkg::CNT_W'(1) : job_head.count;
    sens_eff = (job_r.sens == '0) ? rcm_pkg::SENS_W'(1) : job_r.sens;
    s_trem   = {srem_r, rad_r[rcm_pkg::RAD_W-1 -: 2]};
    s_trial  = {1'b0, root_r, 2'b01};
    s_ge     = s_trem >= s_trial;
    ma_clamped = (div_q > rcm_pkg::DIV_W'(rcm_pkg::CURRENT_MAX))
                 ? rcm_pkg::MA_W'(rcm_pkg::CURRENT_MAX) : div_q[rcm_pkg::MA_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcm_pkg::B_IDLE: begin
        if (!job_empty) begin
          state_nxt = (job_head.kind == rcm_pkg::KIND_CALIB) ? rcm_pkg::B_OUT
                                                              : rcm_pkg::B_DIV1;
        end
      end
      rcm_pkg::B_DIV1: begin
        if (div_done) begin
          state_nxt = rcm_pkg::B_SQRT;
        end
      end
      rcm_pkg::B_SQRT: begin
        if (sqrt_last) begin
          state_nxt = rcm_pkg::B_MUL;
        end
      end
      rcm_pkg::B_MUL: state_nxt = rcm_pkg::B_DIV2;
      rcm_pkg::B_DIV2: begin
        if (div_done) begin
          state_nxt = rcm_pkg::B_OUT;
        end
      end
      rcm_pkg::B_OUT: begin
        if (out_free) begin
          state_nxt = rcm_pkg::B_IDLE;
        end
      end
      default: state_nxt = rcm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_pop      = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    div_dividend = rcm_pkg::DIV_W'(root_r) * rcm_pkg::DIV_W'(rcm_pkg::SCALE_NUM);
    div_divisor  = rcm_pkg::DEN_W'(rcm_pkg::SCALE_DEN) * rcm_pkg::DEN_W'(sens_eff);
    unique case (state_r)
      rcm_pkg::B_IDLE: begin
        job_pop      = !job_empty;
        div_start    = !job_empty && (job_head.kind == rcm_pkg::KIND_RMS);
        div_dividend = rcm_pkg::DIV_W'(job_head.sum);
        div_divisor  = rcm_pkg::DEN_W'(cnt_eff);
      end
      rcm_pkg::B_MUL:  div_start = 1'b1;
      rcm_pkg::B_OUT:  out_load = out_free;
      rcm_pkg::B_DIV1, rcm_pkg::B_SQRT, rcm_pkg::B_DIV2: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcm_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_head;
      ma_r  <= '0;
    end
    if (state_r == rcm_pkg::B_DIV1 && div_done) begin
      rad_r  <= {div_q[rcm_pkg::SUM_W-1:0], (2 * rcm_pkg::FRAC_BITS)'(0)};
      root_r <= '0;
      srem_r <= '0;
      scnt_r <= '0;
    end
    if (state_r == rcm_pkg::B_SQRT) begin
      rad_r  <= {rad_r[rcm_pkg::RAD_W-3:0], 2'b00};
      root_r <= {root_r[rcm_pkg::ROOT_W-2:0], s_ge};
      srem_r <= s_ge ? rcm_pkg::SREM_W'(s_trem - s_trial) : s_trem[rcm_pkg::SREM_W-1:0];
      scnt_r <= scnt_r + 1'b1;
    end
    if (state_r == rcm_pkg::B_DIV2 && div_done) begin
      ma_r <= ma_clamped;
    end
    if (out_load) begin
      out_kind_r <= job_r.kind;
      out_ma_r   <= ma_r;
      out_neut_r <= job_r.neutral;
      out_cnt_r  <= job_r.count;
      out_ovf_r  <= job_r.sat;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_current_ma     = out_ma_r;
  assign out_neutral_code   = out_neut_r;
  assign out_window_samples = out_cnt_r;
  assign out_overflow       = out_ovf_r;

endmodule

[design/rms_current_meter_top.sv]
// channel  direction  handshake            payload
// in       input      in_push / in_full    in_opcode, in_sample, in_window_end
// out      output     out_pop / out_empty  out_kind, out_current_ma, out_neutral_code,
//                                          out_window_samples, out_overflow
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// the front takes one sample per cycle while in_full is low; each sample's square and
// add finish in that cycle; rms results reach the out ports through the mean divider,
// 20 square root steps, a multiply and a second divide; calibration results skip these
// a two-entry queue holds window and calibration jobs; in_full rises only when it is full
// synchronous active-low reset: sums and counts clear, sensitivity 185, neutral 512
// cfg_ready is always high
module rms_current_meter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic [rcm_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           in_window_end,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_kind,
  output logic [rcm_pkg::MA_W-1:0]       out_current_ma,
  output logic [rcm_pkg::SAMPLE_W-1:0]   out_neutral_code,
  output logic [rcm_pkg::CNT_W-1:0]      out_window_samples,
  output logic                           out_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcm_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  rcm_pkg::job_t job_in;
  rcm_pkg::job_t job_head;
  logic          job_push;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;

  assign cfg_ready = 1'b1;
  assign in_full   = job_full;

  rcm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_opcode     (in_opcode),
    .in_sample     (in_sample),
    .in_window_end (in_window_end),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .job_full      (job_full),
    .job_push      (job_push),
    .job           (job_in)
  );

  rcm_job_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_head),
    .full  (job_full),
    .empty (job_empty)
  );

  rcm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_empty          (job_empty),
    .job_head           (job_head),
    .job_pop            (job_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_kind           (out_kind),
    .out_current_ma     (out_current_ma),
    .out_neutral_code   (out_neutral_code),
    .out_window_samples (out_window_samples),
    .out_overflow       (out_overflow)
  );

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import rcm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic                op;
    logic [SAMPLE_W-1:0] code;
    logic                last;
  } adc_item_t;

  typedef struct {
    logic                kind;
    logic [MA_W-1:0]     ma;
    logic [SAMPLE_W-1:0] neutral;
    logic [CNT_W-1:0]    count;
    logic                ovf;
  } meter_reading_t;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_push       = 1'b0;
  logic                 in_full;
  logic                 in_opcode     = 1'b0;
  logic [SAMPLE_W-1:0]  in_sample     = '0;
  logic                 in_window_end = 1'b0;
  logic                 out_empty;
  logic                 out_pop       = 1'b0;
  logic                 out_kind;
  logic [MA_W-1:0]      out_current_ma;
  logic [SAMPLE_W-1:0]  out_neutral_code;
  logic [CNT_W-1:0]     out_window_samples;
  logic                 out_overflow;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata     = '0;

  // predictor copy of the block state and registers
  logic [SENS_W-1:0]   sens_q     = SENS_RESET;
  logic [SAMPLE_W-1:0] neutral_q  = NEUTRAL_RESET;
  logic [SUM_W-1:0]    sq_sum_q   = '0;
  logic [CNT_W-1:0]    win_cnt_q  = '0;
  logic                sat_q      = 1'b0;
  logic [CSUM_W-1:0]   cal_sum_q  = '0;
  logic [CCNT_W-1:0]   cal_cnt_q  = '0;

  adc_item_t      adc_backlog[$];
  meter_reading_t readings_due[$];
  adc_item_t      next_item;

  int  send_gap   = 0;
  bit  send_calm  = 1'b0;
  int  pop_hold   = 0;
  int  hold_now   = 0;
  bit  take_calm  = 1'b0;
  int  cycle_count = 0;
  int  error_count = 0;
  int  n_samples  = 0;
  int  n_rms      = 0;
  int  n_cal      = 0;
  int  n_writes   = 0;

  rms_current_meter_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_opcode          (in_opcode),
    .in_sample          (in_sample),
    .in_window_end      (in_window_end),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_current_ma     (out_current_ma),
    .out_neutral_code   (out_neutral_code),
    .out_window_samples (out_window_samples),
    .out_overflow       (out_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void predict_reading(adc_item_t it);
    meter_reading_t  res;
    logic [SAMPLE_W-1:0] diff;
    longint unsigned acc;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned sensv;
    longint unsigned ma;
    res = '{default: '0};
    if (it.op == OP_CALIB) begin
      cal_sum_q = cal_sum_q + CSUM_W'(it.code);
      cal_cnt_q = cal_cnt_q + 1'b1;
      if (cal_cnt_q >= CALIB_SAMPLES) begin
        neutral_q = SAMPLE_W'(cal_sum_q / CALIB_SAMPLES);
        cal_sum_q = '0;
        cal_cnt_q = '0;
        res.kind    = KIND_CALIB;
        res.neutral = neutral_q;
        readings_due.push_back(res);
        n_cal++;
      end
    end else begin
      diff = (it.code >= neutral_q) ? it.code - neutral_q : neutral_q - it.code;
      acc = 64'(sq_sum_q) + 64'(diff) * 64'(diff);
      if (acc > 64'hFFFF_FFFF) begin
        sq_sum_q = '1;
        sat_q    = 1'b1;
      end else begin
        sq_sum_q = SUM_W'(acc);
      end
      if (win_cnt_q < MAX_WINDOW) win_cnt_q = win_cnt_q + 1'b1;
      if (it.last) begin
        mean  = 64'(sq_sum_q) / ((win_cnt_q != 0) ? 64'(win_cnt_q) : 64'd1);
        root  = floor_sqrt(mean << (2 * FRAC_BITS));
        sensv = (sens_q != 0) ? 64'(sens_q) : 64'd1;
        ma    = (root * 64'd5_000_000) / ((64'd1 << FRAC_BITS) * 64'(ADC_MAX) * sensv);
        if (ma > CURRENT_MAX) ma = CURRENT_MAX;
        res.kind    = KIND_RMS;
        res.ma      = MA_W'(ma);
        res.neutral = neutral_q;
        res.count   = win_cnt_q;
        res.ovf     = sat_q;
        readings_due.push_back(res);
        n_rms++;
        sq_sum_q  = '0;
        win_cnt_q = '0;
        sat_q     = 1'b0;
      end
    end
  endfunction

  task automatic report_error(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_reading();
    meter_reading_t want;
    if (readings_due.size() == 0) begin
      report_error("result popped with nothing expected");
      return;
    end
    want = readings_due.pop_front();
    if (out_kind !== want.kind)
      report_error($sformatf("kind %0d, expected %0d", out_kind, want.kind));
    if (out_current_ma !== want.ma)
      report_error($sformatf("current_ma %0d, expected %0d", out_current_ma, want.ma));
    if (out_neutral_code !== want.neutral)
      report_error($sformatf("neutral_code %0d, expected %0d", out_neutral_code, want.neutral));
    if (out_window_samples !== want.count)
      report_error($sformatf("window_samples %0d, expected %0d", out_window_samples, want.count));
    if (out_overflow !== want.ovf)
      report_error($sformatf("overflow %0d, expected %0d", out_overflow, want.ovf));
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else if (!in_push || !in_full) begin
      if (send_gap > 0) begin
        in_push  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (adc_backlog.size() > 0) begin
        next_item = adc_backlog.pop_front();
        in_push       <= 1'b1;
        in_opcode     <= next_item.op;
        in_sample     <= next_item.code;
        in_window_end <= next_item.last;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        send_gap <= send_calm ? 0 : $urandom_range(0, 5);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted sample, checks each popped result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (in_push && !in_full) begin
        predict_reading('{op: in_opcode, code: in_sample, last: in_window_end});
        n_samples++;
      end
      if (out_pop && !out_empty) begin
        check_reading();
        if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
        hold_now = take_calm ? 0 : $urandom_range(0, 5);
      end else begin
        hold_now = pop_hold;
      end
      if (hold_now > 0) begin
        out_pop  <= 1'b0;
        pop_hold <= hold_now - 1;
      end else begin
        out_pop  <= 1'b1;
        pop_hold <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               readings_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(logic op, logic [SAMPLE_W-1:0] code, logic last);
    adc_backlog.push_back('{op: op, code: code, last: last});
  endtask

  function automatic logic [SAMPLE_W-1:0] near_code(int center, int amp);
    int v;
    v = center + int'($urandom_range(0, 2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SENS:    sens_q = data[SENS_W-1:0];
      REG_NEUTRAL: neutral_q = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  task automatic write_sens(int sens);
    write_reg(REG_SENS, {2'($urandom_range(0, 3)), 8'(sens)});
  endtask

  task automatic settle();
    while (adc_backlog.size() != 0 || in_push || readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly whole windows and calibration groups around the working neutral, some noise
  task automatic queue_traffic(int n, int center);
    int added;
    int pick;
    int len;
    int amp;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
        amp = ($urandom_range(0, 3) == 0) ? ADC_MAX : $urandom_range(0, 200);
        for (int k = 0; k < len; k++)
          add_item(OP_MEASURE, near_code(center, amp), k == len - 1);
        added += len;
      end else if (pick < 88) begin
        for (int k = 0; k < CALIB_SAMPLES; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            add_item(OP_MEASURE, near_code(center, 100), 1'b0);
            added++;
          end
          add_item(OP_CALIB, near_code(center, 30), 1'($urandom_range(0, 1)));
        end
        added += CALIB_SAMPLES;
      end else begin
        add_item(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, ADC_MAX)),
                 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  int phase_sens[8]    = '{185, 100, 66, 250, 1, 255, 50, 0};
  int phase_neutral[8] = '{512, 300, 700, 0, 1023, 0, 0, 0};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero current, extremes, calibration with window_end set
    add_item(OP_MEASURE, 10'd512, 1'b1);
    add_item(OP_MEASURE, 10'd0, 1'b0);
    add_item(OP_MEASURE, 10'd1023, 1'b1);
    for (int k = 0; k < CALIB_SAMPLES; k++)
      add_item(OP_CALIB, (k < CALIB_SAMPLES - 1) ? 10'd1023 : 10'd0, 1'(k % 2));
    // calibration interleaved with an open window
    add_item(OP_MEASURE, 10'd100, 1'b0);
    for (int k = 0; k < CALIB_SAMPLES; k++) begin
      if (k == CALIB_SAMPLES / 2) add_item(OP_MEASURE, 10'd1023, 1'b0);
      add_item(OP_CALIB, 10'd0, 1'b0);
    end
    add_item(OP_MEASURE, 10'd1023, 1'b1);
    settle();

    write_reg(REG_SENS, {2'b11, 8'd50});
    write_reg(REG_NEUTRAL, 10'd0);
    add_item(OP_MEASURE, 10'd1023, 1'b1);
    add_item(OP_MEASURE, 10'd0, 1'b1);
    settle();

    // zero sensitivity, writes to unused indexes
    write_reg(REG_SENS, 10'h200);
    write_reg(REG_SPARE_A, 10'h3FF);
    write_reg(REG_SPARE_B, 10'h155);
    add_item(OP_MEASURE, 10'd1023, 1'b1);
    add_item(OP_MEASURE, 10'd700, 1'b1);
    settle();

    phase_sens[7]    = $urandom_range(0, 255);
    phase_neutral[5] = $urandom_range(0, 1023);
    phase_neutral[6] = $urandom_range(0, 1023);
    phase_neutral[7] = $urandom_range(0, 1023);
    for (int p = 0; p < 8; p++) begin
      write_sens(phase_sens[p]);
      write_reg(REG_NEUTRAL, CFG_DAT_W'(phase_neutral[p]));
      queue_traffic(55, phase_neutral[p]);
      settle();
    end

    $display("covered %0d samples: %0d rms windows, %0d calibrations, %0d register writes",
             n_samples, n_rms, n_cal, n_writes);
    $display("incl. current clamp, zero sensitivity, unused indexes, interleaved calibration");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
